>>> hw/rtl/cvdp_pkg.sv
package cvdp_pkg;

  localparam int DataW  = 32;
  localparam int ProdW  = 40;
  localparam int WideW  = 48;
  localparam int NumOsc = 3;
  localparam int NumIn  = 12;
  localparam int NumOut = 6;
  localparam int IdxW   = 3;
  localparam int BoundW = 31;
  localparam int FracW  = 24;

  localparam logic signed [WideW-1:0] QOne = WideW'(64'sd16777216);

  typedef enum logic [IdxW-1:0] {
    IDX_DETUNE_1     = 3'd0,
    IDX_DETUNE_2     = 3'd1,
    IDX_DETUNE_3     = 3'd2,
    IDX_COUPLING     = 3'd3,
    IDX_EXCITATION   = 3'd4,
    IDX_ESCAPE_BOUND = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [BoundW-1:0]              escape_bound;
    logic [DataW-1:0]               excitation;
    logic [DataW-1:0]               coupling;
    logic [NumOsc-1:0][DataW-1:0]   detune;
  } cfg_t;

  typedef struct packed {
    logic                           esc;
    logic [NumOut-1:0][DataW-1:0]   p;
    logic [NumOut-1:0][DataW-1:0]   r;
  } res_t;

  // Q8.24 operands, Q16.24 product, floor rounding
  function automatic logic signed [ProdW-1:0] mulq(input logic signed [DataW-1:0] a,
                                                   input logic signed [DataW-1:0] b);
    logic signed [2*DataW-1:0] p;
    p = a * b;
    return p[2*DataW-1:FracW];
  endfunction

  function automatic logic signed [WideW-1:0] ext32(input logic signed [DataW-1:0] v);
    return {{(WideW-DataW){v[DataW-1]}}, v};
  endfunction

  function automatic logic signed [WideW-1:0] ext40(input logic signed [ProdW-1:0] v);
    return {{(WideW-ProdW){v[ProdW-1]}}, v};
  endfunction

  function automatic logic signed [DataW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic [WideW-DataW:0] top;
    top = v[WideW-1:DataW-1];
    if ((&top) || !(|top)) begin
      return v[DataW-1:0];
    end else if (v[WideW-1]) begin
      return {1'b1, {(DataW-1){1'b0}}};
    end else begin
      return {1'b0, {(DataW-1){1'b1}}};
    end
  endfunction

endpackage

>>> hw/rtl/cvdp_cfg_regs.sv
module cvdp_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [cvdp_pkg::IdxW-1:0]   cfg_index,
  input  logic [cvdp_pkg::DataW-1:0]  cfg_data,
  output cvdp_pkg::cfg_t              cfg
);
  import cvdp_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.detune       <= '0;
      cfg.coupling     <= '0;
      cfg.excitation   <= DataW'(QOne);
      cfg.escape_bound <= BoundW'(31'h4000_0000);
    end else if (cfg_valid) begin
      case (reg_idx_t'(cfg_index))
        IDX_DETUNE_1:     cfg.detune[0]    <= cfg_data;
        IDX_DETUNE_2:     cfg.detune[1]    <= cfg_data;
        IDX_DETUNE_3:     cfg.detune[2]    <= cfg_data;
        IDX_COUPLING:     cfg.coupling     <= cfg_data;
        IDX_EXCITATION:   cfg.excitation   <= cfg_data;
        IDX_ESCAPE_BOUND: cfg.escape_bound <= cfg_data[BoundW-1:0];
        default: ;
      endcase
    end
  end

endmodule

>>> hw/rtl/cvdp_pipe.sv
module cvdp_pipe (
  input  logic                                    clk,
  input  logic                                    rst,
  input  cvdp_pkg::cfg_t                          cfg,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic [cvdp_pkg::NumIn*cvdp_pkg::DataW-1:0] in_data,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output cvdp_pkg::res_t                          out_res
);
  import cvdp_pkg::*;

  // input stage
  logic                     i_valid;
  logic signed [DataW-1:0]  i_x  [NumOut];
  logic signed [DataW-1:0]  i_dx [NumOut];

  // stage A: squares, cross products, operand prep, escape test
  logic                     a_valid;
  logic                     a_esc;
  logic signed [ProdW-1:0]  a_sq [NumOsc];
  logic signed [ProdW-1:0]  a_xv [NumOsc];
  logic signed [DataW-1:0]  a_cd [NumOsc];
  logic signed [DataW-1:0]  a_od [NumOsc];
  logic signed [DataW-1:0]  a_x  [NumOut];
  logic signed [DataW-1:0]  a_dx [NumOut];

  // stage B: damping and tangent factors, linear products
  logic                     b_valid;
  logic                     b_esc;
  logic signed [DataW-1:0]  b_f   [NumOsc];
  logic signed [DataW-1:0]  b_br  [NumOsc];
  logic signed [ProdW-1:0]  b_pd  [NumOsc];
  logic signed [ProdW-1:0]  b_pc  [NumOsc];
  logic signed [ProdW-1:0]  b_pe  [NumOsc];
  logic signed [DataW-1:0]  b_xo  [NumOsc];
  logic signed [DataW-1:0]  b_dx  [NumOut];

  // stage C: second-level products
  logic                     c_valid;
  logic                     c_esc;
  logic signed [ProdW-1:0]  c_qfx [NumOsc];
  logic signed [ProdW-1:0]  c_qbr [NumOsc];
  logic signed [ProdW-1:0]  c_qdf [NumOsc];
  logic signed [ProdW-1:0]  c_pd  [NumOsc];
  logic signed [ProdW-1:0]  c_pc  [NumOsc];
  logic signed [ProdW-1:0]  c_pe  [NumOsc];
  logic signed [DataW-1:0]  c_xo  [NumOsc];
  logic signed [DataW-1:0]  c_dxo [NumOsc];

  // stage D: sums, saturation, escape mask
  logic                     d_valid;
  res_t                     d_res;

  logic rdy_i, rdy_a, rdy_b, rdy_c, rdy_d;
  logic esc_next;
  logic signed [DataW-1:0]   ep, lm;
  logic signed [BoundW+2:0]  bound_e;

  assign rdy_d    = !d_valid || out_ready;
  assign rdy_c    = !c_valid || rdy_d;
  assign rdy_b    = !b_valid || rdy_c;
  assign rdy_a    = !a_valid || rdy_b;
  assign rdy_i    = !i_valid || rdy_a;
  assign in_ready = rdy_i;

  assign out_valid = d_valid;
  assign out_res   = d_res;

  assign ep      = signed'(cfg.coupling);
  assign lm      = signed'(cfg.excitation);
  assign bound_e = signed'({3'b000, cfg.escape_bound});

  always_comb begin
    logic signed [BoundW+2:0] xe;
    esc_next = 1'b0;
    for (int i = 0; i < NumOut; i++) begin
      xe = {{(BoundW+3-DataW){i_x[i][DataW-1]}}, i_x[i]};
      if ((xe > bound_e) || (xe < -bound_e)) esc_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i_valid <= 1'b0;
    end else if (rdy_i) begin
      i_valid <= in_valid;
    end
    if (rdy_i && in_valid) begin
      for (int i = 0; i < NumOut; i++) begin
        i_x[i]  <= signed'(in_data[DataW*i +: DataW]);
        i_dx[i] <= signed'(in_data[DataW*(NumOut+i) +: DataW]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (rdy_a) begin
      a_valid <= i_valid;
    end
    if (rdy_a && i_valid) begin
      a_esc <= esc_next;
      for (int k = 0; k < NumOsc; k++) begin
        a_sq[k] <= mulq(i_x[2*k], i_x[2*k]);
        a_xv[k] <= mulq(i_x[2*k], i_x[2*k+1]);
        a_od[k] <= sat32(QOne + ext32(signed'(cfg.detune[k])));
      end
      a_cd[0] <= sat32(ext32(i_x[0]) - ext32(i_x[2]));
      a_cd[1] <= sat32((ext32(i_x[2]) <<< 1) - ext32(i_x[0]) - ext32(i_x[4]));
      a_cd[2] <= sat32(ext32(i_x[4]) - ext32(i_x[2]));
      a_x  <= i_x;
      a_dx <= i_dx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (rdy_b) begin
      b_valid <= a_valid;
    end
    if (rdy_b && a_valid) begin
      b_esc <= a_esc;
      for (int k = 0; k < NumOsc; k++) begin
        b_f[k]  <= sat32(ext32(lm) - ext40(a_sq[k]));
        b_br[k] <= sat32(-QOne - ext32(ep) - ((k == 1) ? ext32(ep) : '0)
                         - (ext40(a_xv[k]) <<< 1) - ext32(signed'(cfg.detune[k])));
        b_pd[k] <= mulq(a_od[k], a_x[2*k]);
        b_pc[k] <= mulq(ep, a_cd[k]);
        b_pe[k] <= mulq(a_dx[2*k], ep);
        b_xo[k] <= a_x[2*k+1];
      end
      b_dx <= a_dx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (rdy_c) begin
      c_valid <= b_valid;
    end
    if (rdy_c && b_valid) begin
      c_esc <= b_esc;
      for (int k = 0; k < NumOsc; k++) begin
        c_qfx[k] <= mulq(b_f[k], b_xo[k]);
        c_qbr[k] <= mulq(b_dx[2*k], b_br[k]);
        c_qdf[k] <= mulq(b_dx[2*k+1], b_f[k]);
        c_dxo[k] <= b_dx[2*k+1];
      end
      c_pd <= b_pd;
      c_pc <= b_pc;
      c_pe <= b_pe;
      c_xo <= b_xo;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (rdy_d) begin
      d_valid <= c_valid;
    end
    if (rdy_d && c_valid) begin
      d_res.esc <= c_esc;
      if (c_esc) begin
        d_res.r <= '0;
        d_res.p <= '0;
      end else begin
        for (int k = 0; k < NumOsc; k++) begin
          d_res.r[2*k]   <= c_xo[k];
          d_res.r[2*k+1] <= sat32(ext40(c_qfx[k]) - ext40(c_pd[k]) - ext40(c_pc[k]));
          d_res.p[2*k]   <= c_dxo[k];
        end
        d_res.p[1] <= sat32(ext40(c_qbr[0]) + ext40(c_qdf[0]) + ext40(c_pe[1]));
        d_res.p[3] <= sat32(ext40(c_qbr[1]) + ext40(c_qdf[1]) + ext40(c_pe[2])
                            + ext40(c_pe[0]));
        d_res.p[5] <= sat32(ext40(c_qbr[2]) + ext40(c_qdf[2]) + ext40(c_pe[1]));
      end
    end
  end

endmodule

>>> hw/rtl/cvdp_out_ser.sv
module cvdp_out_ser (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_ready,
  input  cvdp_pkg::res_t                           in_res,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [cvdp_pkg::NumOut*cvdp_pkg::DataW-1:0] m_axis_tdata,
  output logic                                     m_axis_tlast,
  output logic                                     m_axis_tuser
);
  import cvdp_pkg::*;

  logic full;
  logic phase;
  res_t held;
  logic beat;
  logic load;

  assign beat     = full && m_axis_tready;
  assign in_ready = !full || (beat && phase);
  assign load     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full  <= 1'b0;
      phase <= 1'b0;
    end else if (load) begin
      full  <= 1'b1;
      phase <= 1'b0;
    end else if (beat) begin
      full  <= !phase;
      phase <= !phase;
    end
    if (load) begin
      held <= in_res;
    end
  end

  assign m_axis_tvalid = full;
  assign m_axis_tdata  = phase ? held.p : held.r;
  assign m_axis_tlast  = phase;
  assign m_axis_tuser  = held.esc;

endmodule

>>> hw/rtl/coupled_van_der_pol_rhs.sv
// An accepted input beat passes the input, A, B, C and D pipeline registers and the
// output holding register before its first result beat; the second (tlast) beat follows it.
// Sustained input rate is bounded by the single result port carrying two beats per item;
// the 5-stage pipeline takes a new item each cycle while its output is not stalled.
// Reset (rst, synchronous): empties the pipeline and loads register defaults.
module coupled_van_der_pol_rhs (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_valid,
  output logic                                     cfg_ready,
  input  logic [cvdp_pkg::IdxW-1:0]                cfg_index,
  input  logic [cvdp_pkg::DataW-1:0]               cfg_data,
  input  logic                                     s_axis_tvalid,
  output logic                                     s_axis_tready,
  // pos_1, vel_1, pos_2, vel_2, pos_3, vel_3,
  // pert_pos_1, pert_vel_1, pert_pos_2, pert_vel_2, pert_pos_3, pert_vel_3
  input  logic [cvdp_pkg::NumIn*cvdp_pkg::DataW-1:0]  s_axis_tdata,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  // deriv_0, deriv_1, deriv_2, deriv_3, deriv_4, deriv_5
  output logic [cvdp_pkg::NumOut*cvdp_pkg::DataW-1:0] m_axis_tdata,
  output logic                                     m_axis_tlast,  // last_result
  output logic                                     m_axis_tuser   // out_of_bounds
);
  import cvdp_pkg::*;

  cfg_t cfg;
  res_t pipe_res;
  logic pipe_valid;
  logic pipe_ready;

  cvdp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  cvdp_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (pipe_valid),
    .out_ready (pipe_ready),
    .out_res   (pipe_res)
  );

  cvdp_out_ser u_ser (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (pipe_valid),
    .in_ready      (pipe_ready),
    .in_res        (pipe_res),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

`ifndef ASSERT_OFF
  a_last_follows: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tvalid && m_axis_tlast))
    else $error("second result beat missing");

  a_flag_pair: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast) |=> (m_axis_tuser == $past(m_axis_tuser)))
    else $error("escape flag differs between result beats");

  a_escape_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata == '0))
    else $error("escaped result not zeroed");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with no pending result");
`endif

endmodule
